// ===== hw/rtl/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and codes for the searchable FIFO queue.
// ----------------------------------------------------------------------------
package fqs_pkg;

   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 4;

   typedef logic [ACTION_W-1:0]        action_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [STATUS_W-1:0]        status_type;
   typedef logic [POS_W-1:0]           position_type;

   // Request codes. The unused code behaves as a search.
   localparam action_type ACT_INSERT     = 2'd0;
   localparam action_type ACT_REMOVE     = 2'd1;
   localparam action_type ACT_SEARCH     = 2'd2;
   localparam action_type ACT_SEARCH_ALT = 2'd3;

   // Result codes.
   localparam status_type ST_INSERTED  = 3'd0;
   localparam status_type ST_REMOVED   = 3'd1;
   localparam status_type ST_FOUND     = 3'd2;
   localparam status_type ST_NOT_FOUND = 3'd3;
   localparam status_type ST_EMPTY     = 3'd4;
   localparam status_type ST_FULL      = 3'd5;

   // Commands from the controller to the queue store.
   typedef struct packed {
      logic insert;    // write at tail and advance it
      logic remove;    // drop the head entry
      logic rd_first;  // start a scan: read the head entry
      logic rd_next;   // continue a scan: read the following entry
   } store_cmd_type;

   // Flags from the queue store to the controller.
   typedef struct packed {
      logic empty;
      logic full;
   } store_flags_type;

endpackage

// ===== hw/rtl/fqs_if.sv =====
// ----------------------------------------------------------------------------
// fqs_req_if / fqs_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface fqs_req_if;
   import fqs_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   value_type  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface fqs_rsp_if;
   import fqs_pkg::*;

   logic         valid;
   logic         ready;
   status_type   status;
   position_type position;

   modport source (output valid, output status, output position, input ready);
   modport sink   (input valid, input status, input position, output ready);
endinterface

// ===== hw/rtl/fqs_store.sv =====
// ----------------------------------------------------------------------------
// fqs_store
// Entry memory of the queue with its head, tail and occupancy registers and
// a registered read port that walks from the head during a scan.
// ----------------------------------------------------------------------------
module fqs_store #(
   parameter int DEPTH = 16,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int OCC_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fqs_pkg::store_cmd_type   cmd,
   input  fqs_pkg::value_type       wr_data,
   output fqs_pkg::value_type       rd_data,
   output logic [OCC_W-1:0]         occupancy,
   output fqs_pkg::store_flags_type flags
);
   import fqs_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

   value_type        mem [DEPTH];
   value_type        rd_data_ff;
   logic [IDX_W-1:0] head_ff, tail_ff, rd_addr_ff, rd_addr_in;
   logic [OCC_W-1:0] occ_ff;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   always_comb begin
      if (cmd.rd_first) begin
         rd_addr_in = head_ff;
      end else if (cmd.rd_next) begin
         rd_addr_in = next_idx(rd_addr_ff);
      end else begin
         rd_addr_in = rd_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_data_ff <= mem[rd_addr_in];
      if (cmd.insert) begin
         mem[tail_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (cmd.insert) begin
         tail_ff <= next_idx(tail_ff);
         occ_ff  <= occ_ff + 1'b1;
      end else if (cmd.remove) begin
         occ_ff <= occ_ff - 1'b1;
         // A queue that drains starts again at entry zero.
         if (occ_ff == OCC_W'(1)) begin
            head_ff <= '0;
            tail_ff <= '0;
         end else begin
            head_ff <= next_idx(head_ff);
         end
      end
   end

   assign rd_data     = rd_data_ff;
   assign occupancy   = occ_ff;
   assign flags.empty = (occ_ff == '0);
   assign flags.full  = (occ_ff >= FULL_OCC);

endmodule

// ===== hw/rtl/fifo_queue_with_search_top.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search_top
// Bounded FIFO queue of signed 32-bit values with a linear search.
// ----------------------------------------------------------------------------
// Each request word on req_ch carries an action and a value: insert the
// value at the tail, remove the head entry, or search for the value from
// the head. Every request gives exactly one result word on rsp_ch with a
// status code and, for a found search, the position of the first match
// counted from the head.
// Insert and remove finish in idle: the result word is valid in the cycle
// after the request is accepted when the output register is free. A search
// reads the entry memory one entry per cycle through its registered read
// port from the head and ends at the first match or after the last entry;
// a search of an empty queue finishes at once in idle. A new request is
// accepted once the previous one has finished.
// The result goes into an output register. If the receiver stalls while
// that register is still full, one further finished result is held inside
// and requests wait until it moves into the output register.
// Reset clears the head, tail and occupancy and empties the output
// register; the entry memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module fifo_queue_with_search_top #(
   parameter int DEPTH = 16
) (
   input logic     clock,
   input logic     reset,
   fqs_req_if.sink   req_ch,
   fqs_rsp_if.source rsp_ch
);
   import fqs_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_HOLD
   } state_type;

   state_type       state_ff;
   store_cmd_type   cmd;
   store_flags_type flags;
   value_type       rd_data;
   logic [OCC_W-1:0] occupancy;

   value_type        key_ff;
   logic [IDX_W-1:0] scan_k_ff;

   logic         rsp_valid_ff;
   status_type   rsp_status_ff, pend_status_ff;
   position_type rsp_pos_ff, pend_pos_ff;

   logic         fin;
   status_type   fin_status;
   position_type fin_pos;
   logic         out_free;
   logic         out_load;

   fqs_store #(.DEPTH(DEPTH)) u_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .wr_data   (req_ch.value),
      .rd_data   (rd_data),
      .occupancy (occupancy),
      .flags     (flags)
   );

   // Decode the request in idle, and judge the entry that the memory
   // returns during a scan.
   always_comb begin
      cmd        = '0;
      fin        = 1'b0;
      fin_status = ST_NOT_FOUND;
      fin_pos    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.action)
                  ACT_INSERT: begin
                     fin = 1'b1;
                     if (flags.full) begin
                        fin_status = ST_FULL;
                     end else begin
                        fin_status = ST_INSERTED;
                        cmd.insert = 1'b1;
                     end
                  end
                  ACT_REMOVE: begin
                     fin = 1'b1;
                     if (flags.empty) begin
                        fin_status = ST_EMPTY;
                     end else begin
                        fin_status = ST_REMOVED;
                        cmd.remove = 1'b1;
                     end
                  end
                  default: begin
                     // Search, which the unused code also selects.
                     if (flags.empty) begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_FOUND;
                     end else begin
                        cmd.rd_first = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_data == key_ff) begin
               fin        = 1'b1;
               fin_status = ST_FOUND;
               fin_pos    = POS_W'(scan_k_ff);
            end else if (OCC_W'(scan_k_ff) + 1'b1 == occupancy) begin
               fin        = 1'b1;
               fin_status = ST_NOT_FOUND;
            end else begin
               cmd.rd_next = 1'b1;
            end
         end
         S_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   // The output register can take a result when it is empty or is being
   // taken in this cycle.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // A finished result enters the output register from idle or scan when the
   // register is free, and a held result enters as soon as the word ahead of
   // it is taken.
   always_comb begin
      unique case (state_ff)
         S_IDLE:  out_load = req_ch.valid && fin && out_free;
         S_SCAN:  out_load = fin && out_free;
         S_HOLD:  out_load = rsp_ch.ready;
         default: out_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  key_ff    <= req_ch.value;
                  scan_k_ff <= '0;
                  if (!fin) begin
                     state_ff <= S_SCAN;
                  end else if (out_free) begin
                     rsp_status_ff <= fin_status;
                     rsp_pos_ff    <= fin_pos;
                  end else begin
                     pend_status_ff <= fin_status;
                     pend_pos_ff    <= fin_pos;
                     state_ff       <= S_HOLD;
                  end
               end
            end
            S_SCAN: begin
               if (!fin) begin
                  scan_k_ff <= scan_k_ff + 1'b1;
               end else if (out_free) begin
                  rsp_status_ff <= fin_status;
                  rsp_pos_ff    <= fin_pos;
                  state_ff      <= S_IDLE;
               end else begin
                  pend_status_ff <= fin_status;
                  pend_pos_ff    <= fin_pos;
                  state_ff       <= S_HOLD;
               end
            end
            S_HOLD: begin
               if (rsp_ch.ready) begin
                  rsp_status_ff <= pend_status_ff;
                  rsp_pos_ff    <= pend_pos_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.position = rsp_pos_ff;

endmodule

// ===== test/fqs_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqs_result_checker
// Tracks the queue contents from the accepted request words, predicts the
// result word of each one and compares it with the word the block returns.
// ----------------------------------------------------------------------------
module fqs_result_checker
   import fqs_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   fqs_req_if   req_mon,
   fqs_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   outstanding
);

   typedef struct packed {
      status_type   status;
      position_type position;
   } queue_result_type;

   value_type        stored_values [DEPTH];
   int               head_slot;
   int               tail_slot;
   int               fill_level;
   queue_result_type expected_results [$];

   function automatic int next_slot(int slot);
      return (slot + 1 >= DEPTH) ? 0 : slot + 1;
   endfunction

   // Applies one request to the local copy of the queue and returns the
   // result word that the block should produce for it.
   function automatic queue_result_type apply_request(action_type act,
                                                      value_type val);
      queue_result_type res;
      int               slot;
      bit               hit;
      res.status   = ST_NOT_FOUND;
      res.position = '0;
      case (act)
         ACT_INSERT: begin
            if (fill_level >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               stored_values[tail_slot] = val;
               tail_slot  = next_slot(tail_slot);
               fill_level = fill_level + 1;
               res.status = ST_INSERTED;
            end
         end
         ACT_REMOVE: begin
            if (fill_level == 0) begin
               res.status = ST_EMPTY;
            end else begin
               fill_level = fill_level - 1;
               if (fill_level == 0) begin
                  head_slot = 0;
                  tail_slot = 0;
               end else begin
                  head_slot = next_slot(head_slot);
               end
               res.status = ST_REMOVED;
            end
         end
         default: begin
            // Both search codes scan from the head for the first match.
            slot = head_slot;
            hit  = 1'b0;
            for (int k = 0; k < fill_level && !hit; k++) begin
               if (stored_values[slot] == val) begin
                  hit          = 1'b1;
                  res.status   = ST_FOUND;
                  res.position = position_type'(k);
               end
               slot = next_slot(slot);
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         head_slot      = 0;
         tail_slot      = 0;
         fill_level     = 0;
         mismatch_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("unexpected result word: status %0d position %0d",
                           rsp_mon.status, rsp_mon.position);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.status !== want.status ||
                   rsp_mon.position !== want.position) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display({"result mismatch: expected status %0d position %0d,",
                               " got status %0d position %0d"},
                              want.status, want.position,
                              rsp_mon.status, rsp_mon.position);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(apply_request(req_mon.action, req_mon.value));
      end
      outstanding = expected_results.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives request words into the searchable FIFO queue, idles both channels
// at random and lets a checker beside the block predict every result word.
// ----------------------------------------------------------------------------
module tb_top;
   import fqs_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 650;
   // From this many random words on, neither side idles any more.
   localparam int QUIET_FROM   = 560;
   localparam int CYCLE_LIMIT  = 400000;
   // Wait well past a search over a full queue before the final check.
   localparam int DRAIN_CYCLES = 40;

   localparam value_type LAST_MARK = 32'h13579bdf;
   localparam value_type FULL_PROBE = 32'h2468ace0;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   logic      clock;
   logic      reset;
   bit        sender_idles;
   bit        receiver_stalls;
   bit        quiet_tail;
   int        mismatch_count;
   int        outstanding;
   int        cycle_count;
   value_type value_pool [16];

   fqs_req_if req_ch ();
   fqs_rsp_if rsp_ch ();

   fifo_queue_with_search_top #(
      .DEPTH (QUEUE_DEPTH)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The checker watches both channels and keeps the expected result words.
   fqs_result_checker #(
      .DEPTH (QUEUE_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("tb_top failed");
      $finish;
   end

   // The receiver stalls in random bursts while stalls are enabled, and
   // takes every result word at once in the quiet tail.
   initial begin
      int stall_len;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_stalls && !quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_len = $urandom_range(1, 15);
            rsp_ch.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Offers one request word, possibly after an idle burst, and returns in
   // the time step of the edge at which the block accepted it. The ready seen
   // right after the edge is still the value that the edge sampled.
   task automatic send_word(action_type act, value_type val);
      int gap_len;
      if (sender_idles && !quiet_tail && $urandom_range(0, 4) == 0) begin
         gap_len = $urandom_range(1, 15);
         req_ch.valid <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.value  <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Holds the request channel idle until every expected result word has
   // come back. The count is read at the falling edge, clear of the updates.
   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Most values come from a small pool so that searches hit often; the
   // rest are fully random so that every bit of the value toggles.
   function automatic value_type pick_value();
      if ($urandom_range(0, 9) < 7)
         return value_pool[$urandom_range(0, 15)];
      return value_type'($urandom);
   endfunction

   // The traffic mode leans toward inserts or removes so that the queue
   // spends time both full and empty, and wraps its head and tail.
   function automatic action_type pick_action(traffic_mode_type mode);
      int roll;
      int insert_pct;
      int remove_pct;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            insert_pct = 65;
            remove_pct = 15;
         end
         MODE_DRAIN: begin
            insert_pct = 15;
            remove_pct = 65;
         end
         default: begin
            insert_pct = 35;
            remove_pct = 30;
         end
      endcase
      if (roll < insert_pct)
         return ACT_INSERT;
      if (roll < insert_pct + remove_pct)
         return ACT_REMOVE;
      return ($urandom_range(0, 3) == 0) ? ACT_SEARCH_ALT : ACT_SEARCH;
   endfunction

   initial begin
      traffic_mode_type mode;
      int               seg_len;
      int               sent_random;
      bit               paused;

      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_INSERT;
      req_ch.value  <= '0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      quiet_tail      = 1'b0;
      sent_random     = 0;
      paused          = 1'b0;

      value_pool[0] = 32'h80000000;
      value_pool[1] = 32'h7fffffff;
      value_pool[2] = 32'h00000000;
      value_pool[3] = 32'hffffffff;
      value_pool[4] = 32'h00000001;
      value_pool[5] = 32'h55555555;
      value_pool[6] = 32'haaaaaaaa;
      for (int i = 7; i < 16; i++)
         value_pool[i] = value_type'($urandom);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. An empty queue first: a remove reports empty and
      // both search codes report not found.
      send_word(ACT_REMOVE, '0);
      send_word(ACT_SEARCH, '0);
      send_word(ACT_SEARCH_ALT, 32'h7fffffff);

      // Fill the queue with the extremes of the value field and a second
      // zero further back, so that a search must report the first match.
      send_word(ACT_INSERT, 32'h80000000);
      send_word(ACT_INSERT, 32'h7fffffff);
      send_word(ACT_INSERT, 32'h00000000);
      send_word(ACT_INSERT, 32'hffffffff);
      for (int k = 4; k < QUEUE_DEPTH; k++)
         send_word(ACT_INSERT, (k == 9) ? value_type'(0) :
                               (k == QUEUE_DEPTH - 1) ? LAST_MARK : value_type'($urandom));

      // The queue is full: an insert reports full and is dropped, the last
      // entry is found at the deepest position and the dropped value is not.
      send_word(ACT_INSERT, FULL_PROBE);
      send_word(ACT_SEARCH, LAST_MARK);
      send_word(ACT_SEARCH, '0);
      send_word(ACT_SEARCH_ALT, FULL_PROBE);
      send_word(ACT_SEARCH, 32'h80000000);

      // One remove and one insert wrap the queue's contents around the end of the
      // store; the new entry then sits at the deepest position again.
      send_word(ACT_REMOVE, '0);
      send_word(ACT_INSERT, FULL_PROBE);
      send_word(ACT_SEARCH, FULL_PROBE);

      // Let the directed part settle completely before random traffic.
      wait_until_drained();

      // Random part, in segments with their own traffic mode and their own
      // choice of whether either side idles.
      while (sent_random < RANDOM_ITEMS) begin
         mode            = traffic_mode_type'($urandom_range(0, 2));
         seg_len         = $urandom_range(20, 60);
         sender_idles    = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         value_pool[$urandom_range(7, 15)] = value_type'($urandom);
         value_pool[$urandom_range(7, 15)] = value_type'($urandom);
         for (int i = 0; i < seg_len && sent_random < RANDOM_ITEMS; i++) begin
            quiet_tail = (sent_random >= QUIET_FROM);
            send_word(pick_action(mode), pick_value());
            sent_random = sent_random + 1;
            // Halfway through, the sender stops until everything has returned.
            if (!paused && sent_random >= RANDOM_ITEMS / 2) begin
               paused = 1'b1;
               wait_until_drained();
            end
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (outstanding != 0)
         $display("result words still expected: %0d", outstanding);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/fqs_pkg.sv
hw/rtl/fqs_if.sv
hw/rtl/fqs_store.sv
hw/rtl/fifo_queue_with_search_top.sv
test/fqs_result_checker.sv
test/tb_top.sv
